@@ hdl/cnc_rlc_pkg.sv @@
// Shared types, codes and keyword constants for the reply line classifier.
package cnc_rlc_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned WinDepth  = 9;              // previous characters kept
  localparam int unsigned WinBits   = (WinDepth + 1) * CharWidth;
  localparam int unsigned KwCount   = 9;
  localparam int unsigned SeenBits  = KwCount + 1;    // keywords plus the '=' flag
  localparam int unsigned EqBit     = KwCount;
  localparam int unsigned PosMax    = 4;              // position counter saturates here

  typedef logic [CharWidth-1:0] char_t;
  typedef logic [3:0]           kind_t;
  typedef logic [2:0]           pos_t;

  // Reply kind codes
  localparam kind_t KIND_STARTUP  = 4'd0;
  localparam kind_t KIND_STATUS   = 4'd1;
  localparam kind_t KIND_OK       = 4'd2;
  localparam kind_t KIND_ERROR    = 4'd3;
  localparam kind_t KIND_ALARM    = 4'd4;
  localparam kind_t KIND_LOCKED   = 4'd5;
  localparam kind_t KIND_HELP     = 4'd6;
  localparam kind_t KIND_UNLOCKED = 4'd7;
  localparam kind_t KIND_ENABLED  = 4'd8;
  localparam kind_t KIND_DISABLED = 4'd9;
  localparam kind_t KIND_PROBE    = 4'd10;
  localparam kind_t KIND_CONFIG   = 4'd11;
  localparam kind_t KIND_PARSER   = 4'd12;

  // Special characters
  localparam char_t CHAR_LT     = 8'h3C;  // '<'
  localparam char_t CHAR_GT     = 8'h3E;  // '>'
  localparam char_t CHAR_DOLLAR = 8'h24;  // '$'
  localparam char_t CHAR_EQ     = 8'h3D;  // '='

  // Startup banner prefix, first character first
  localparam char_t START_TEXT [4] = '{8'h47, 8'h72, 8'h62, 8'h6C};

  // Keywords right-aligned in the window: the current character is the low byte
  localparam logic [WinBits-1:0] KW_TEXT [KwCount] = '{
    80'("ok"), 80'("error"), 80'("ALARM"), 80'("to unlock"), 80'("HLP"),
    80'("Unlocked"), 80'("[Enabled]"), 80'("[Disabled]"), 80'("PRB")
  };
  localparam int unsigned KW_LEN [KwCount] = '{2, 5, 5, 9, 3, 8, 9, 10, 3};

  // Byte mask covering the low len characters of the window
  function automatic logic [WinBits-1:0] byte_mask(input int unsigned len);
    logic [WinBits-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < WinDepth + 1; i++) begin
      if (i < len) m[i*CharWidth +: CharWidth] = {CharWidth{1'b1}};
    end
    return m;
  endfunction

  // Request held in the input register
  typedef struct packed {
    logic  go;     // request is processed this cycle
    logic  last;   // request carries the end-of-line mark
    char_t ch;
  } step_t;

  // Result handed to the output register
  typedef struct packed {
    logic  load;
    kind_t kind;
  } res_t;

endpackage

@@ hdl/cnc_rlc_input_stage.sv @@
// Input register and request handshake of the reply line classifier.
module cnc_rlc_input_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  output logic                 line_stall,
  input  logic [7:0]           line_byte,
  input  logic                 final_byte,
  input  logic                 open,
  output cnc_rlc_pkg::step_t   step
);
  import cnc_rlc_pkg::*;

  logic  vld;
  logic  last;
  char_t ch;
  logic  go;
  logic  load;

  // Process a held request unless it ends a line and the result slot is full
  assign go         = vld && (!last || open);
  assign load       = !vld || go;
  assign line_stall = vld && !go;

  // Hold or replace the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= line_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && line_valid) begin
      ch   <= line_byte;
      last <= final_byte;
    end
  end

  assign step = '{go: go, last: last, ch: ch};

endmodule

@@ hdl/cnc_rlc_scan.sv @@
// Line state, keyword window match and reply classification.
module cnc_rlc_scan (
  input  logic                clk,
  input  logic                rst,
  input  cnc_rlc_pkg::step_t  step,
  output cnc_rlc_pkg::res_t   res
);
  import cnc_rlc_pkg::*;

  logic [WinBits-CharWidth-1:0] recent;      // low byte is the most recent char
  logic [SeenBits-1:0]          seen;
  char_t                        first_char;
  pos_t                         pos;
  logic                         pfx;

  logic [WinBits-CharWidth-1:0] recent_next;
  logic [SeenBits-1:0]          seen_next;
  char_t                        first_next;
  pos_t                         pos_next;
  logic                         pfx_next;
  logic [WinBits-1:0]           win;
  logic [KwCount-1:0]           hit;
  kind_t                        kind;

  // Match every keyword against the tail of the window
  always_comb begin
    win = {recent, step.ch};
    for (int unsigned k = 0; k < KwCount; k++) begin
      hit[k] = ((win ^ KW_TEXT[k]) & byte_mask(KW_LEN[k])) == '0;
    end
  end

  // Next line state
  always_comb begin
    recent_next = win[WinBits-CharWidth-1:0];
    seen_next   = seen | {step.ch == CHAR_EQ, hit};
    first_next  = first_char;
    pfx_next    = pfx;
    pos_next    = pos;
    if (pos == '0) begin
      first_next = step.ch;
      pfx_next   = (step.ch == START_TEXT[0]);
    end else if (pos < pos_t'(PosMax)) begin
      if (step.ch != START_TEXT[pos[1:0]]) pfx_next = 1'b0;
    end
    if (pos < pos_t'(PosMax)) pos_next = pos + pos_t'(1);
  end

  // Classify by fixed priority
  always_comb begin
    kind = KIND_PARSER;
    if (pos_next == pos_t'(PosMax) && pfx_next) begin
      kind = KIND_STARTUP;
    end else if (first_next == CHAR_LT && step.ch == CHAR_GT) begin
      kind = KIND_STATUS;
    end else begin
      for (int k = KwCount - 1; k >= 0; k--) begin
        if (seen_next[k]) kind = KIND_OK + kind_t'(k);
      end
      if (seen_next[KwCount-1:0] == '0 && first_next == CHAR_DOLLAR && seen_next[EqBit]) begin
        kind = KIND_CONFIG;
      end
    end
  end

  // Advance line state; clear it at the end of a line
  always_ff @(posedge clk) begin
    if (rst || (step.go && step.last)) begin
      recent     <= '0;
      seen       <= '0;
      first_char <= '0;
      pos        <= '0;
      pfx        <= 1'b0;
    end else if (step.go) begin
      recent     <= recent_next;
      seen       <= seen_next;
      first_char <= first_next;
      pos        <= pos_next;
      pfx        <= pfx_next;
    end
  end

  assign res = '{load: step.go && step.last, kind: kind};

endmodule

@@ hdl/cnc_rlc_output_stage.sv @@
// Result register and reply handshake of the reply line classifier.
module cnc_rlc_output_stage (
  input  logic               clk,
  input  logic               rst,
  input  cnc_rlc_pkg::res_t  res,
  output logic               open,
  output logic               reply_valid,
  input  logic               reply_stall,
  output logic [3:0]         reply_kind
);
  import cnc_rlc_pkg::*;

  kind_t kind;

  // Slot can take a new result when empty or being drained
  assign open = !reply_valid || !reply_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (open) begin
      reply_valid <= res.load;
    end
  end

  always_ff @(posedge clk) begin
    if (open && res.load) begin
      kind <= res.kind;
    end
  end

  assign reply_kind = kind;

endmodule

@@ hdl/cnc_response_line_classifier.sv @@
// Top level of the reply line classifier.
//
// Usage: feed one reply line from the motion controller, one character per
// request on the line channel (line_valid, line_stall, line_byte, final_byte),
// with final_byte set on the last character. For every line exactly one reply
// appears on the reply channel (reply_valid, reply_stall, reply_kind) carrying
// the line's type code; other characters produce nothing.
// The final character passes the input register, then the reply register.
// Throughput: one character per cycle unless line_stall is high, set by the
// window compare between the input register and the line state registers.
// Reset (rst, synchronous) empties both registers and clears the line state.
// While the receiver stalls a waiting reply, characters that do not end a line
// keep flowing; a character that ends a line is held in the input register and
// line_stall rises until the reply register frees up.
module cnc_response_line_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  output logic       line_stall,
  input  logic [7:0] line_byte,
  input  logic       final_byte,
  output logic       reply_valid,
  input  logic       reply_stall,
  output logic [3:0] reply_kind
);
  import cnc_rlc_pkg::*;

  step_t step;
  res_t  res;
  logic  open;

  cnc_rlc_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_byte  (line_byte),
    .final_byte (final_byte),
    .open       (open),
    .step       (step)
  );

  cnc_rlc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (res)
  );

  cnc_rlc_output_stage u_output (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .open        (open),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_kind  (reply_kind)
  );

endmodule

@@ hdl/cnc_rlc_checker.sv @@
// Port-level checks for the reply line classifier, bound to the top level.
module cnc_rlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       line_valid,
  input logic       line_stall,
  input logic       final_byte,
  input logic       reply_valid,
  input logic       reply_stall,
  input logic [3:0] reply_kind
);
  import cnc_rlc_pkg::*;

  // Only defined codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    reply_valid |-> reply_kind <= KIND_PARSER)
    else $error("reply kind out of range");

  // Hold a stalled reply
  assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_stall |=> reply_valid && $stable(reply_kind))
    else $error("stalled reply changed");

  // Back-pressure on characters only while a reply is blocked
  assert property (@(posedge clk) disable iff (rst)
    line_stall |-> reply_valid && reply_stall)
    else $error("line stalled without a blocked reply");

  // A new reply follows a taken final character, or one held by line_stall
  assert property (@(posedge clk) disable iff (rst)
    $rose(reply_valid) |->
      $past(line_valid && !line_stall && final_byte, 2) || $past(line_stall, 2))
    else $error("reply without a final character");

  // Nothing is pending right after reset
  assert property (@(posedge clk) rst |=> !reply_valid && !line_stall)
    else $error("block not empty after reset");

endmodule

bind cnc_response_line_classifier cnc_rlc_checker u_cnc_rlc_checker (
  .clk         (clk),
  .rst         (rst),
  .line_valid  (line_valid),
  .line_stall  (line_stall),
  .final_byte  (final_byte),
  .reply_valid (reply_valid),
  .reply_stall (reply_stall),
  .reply_kind  (reply_kind)
);

@@ bench/reply_kind_checker.sv @@
// Checker for the reply line classifier: predicts each line's kind and compares replies.
module reply_kind_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  input  logic       line_stall,
  input  logic [7:0] line_byte,
  input  logic       final_byte,
  input  logic       reply_valid,
  input  logic       reply_stall,
  input  logic [3:0] reply_kind,
  output int         fail_count,
  output int         kinds_waiting
);
  import cnc_rlc_pkg::*;

  // Keywords in priority order, right-aligned: the last character is the low byte
  localparam logic [79:0] KEYWORDS [KwCount] = '{
    80'("ok"), 80'("error"), 80'("ALARM"), 80'("to unlock"), 80'("HLP"),
    80'("Unlocked"), 80'("[Enabled]"), 80'("[Disabled]"), 80'("PRB")
  };
  localparam int KEYWORD_LEN [KwCount] = '{2, 5, 5, 9, 3, 8, 9, 10, 3};

  // Startup banner prefix, first character first
  localparam char_t BANNER [4] = '{8'h47, 8'h72, 8'h62, 8'h6C};

  // Line state of the predictor
  char_t         line_hist [WinDepth];  // oldest first
  logic [10:0]   seen_flags;
  char_t         lead_char;
  logic [2:0]    char_count;
  logic          banner_ok;
  kind_t         expected_kinds [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_line();
    for (int i = 0; i < WinDepth; i++) line_hist[i] = '0;
    seen_flags = '0;
    lead_char  = '0;
    char_count = '0;
    banner_ok  = 1'b0;
  endtask

  // Advance the line state by one character; on the last one queue the kind
  task automatic take_char(input char_t c, input logic last);
    logic [79:0] win;
    logic        hit;
    logic        found;
    kind_t       kind;
    win[7:0] = c;
    for (int i = 0; i < WinDepth; i++) win[(i+1)*8 +: 8] = line_hist[WinDepth-1-i];

    // track the banner prefix over the first four characters
    if (char_count == 0) begin
      lead_char = c;
      banner_ok = (c == BANNER[0]);
    end else if (char_count < 4) begin
      if (c != BANNER[char_count[1:0]]) banner_ok = 1'b0;
    end
    if (char_count < 4) char_count++;

    // set sticky keyword flags
    for (int k = 0; k < KwCount; k++) begin
      hit = 1'b1;
      for (int i = 0; i < KEYWORD_LEN[k]; i++) begin
        if (win[i*8 +: 8] != KEYWORDS[k][i*8 +: 8]) hit = 1'b0;
      end
      if (hit) seen_flags[k] = 1'b1;
    end
    if (c == CHAR_EQ) seen_flags[EqBit] = 1'b1;

    // shift the window
    for (int i = 0; i < WinDepth - 1; i++) line_hist[i] = line_hist[i+1];
    line_hist[WinDepth-1] = c;

    if (last) begin
      if (char_count >= 4 && banner_ok) begin
        kind = KIND_STARTUP;
      end else if (lead_char == CHAR_LT && c == CHAR_GT) begin
        kind = KIND_STATUS;
      end else begin
        kind  = KIND_PARSER;
        found = 1'b0;
        for (int k = 0; k < KwCount; k++) begin
          if (!found && seen_flags[k]) begin
            kind  = KIND_OK + kind_t'(k);
            found = 1'b1;
          end
        end
        if (!found && lead_char == CHAR_DOLLAR && seen_flags[EqBit]) kind = KIND_CONFIG;
      end
      expected_kinds.push_back(kind);
      clear_line();
    end
  endtask

  // Watch both channels
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_kinds.delete();
    end else begin
      if (reply_valid && !reply_stall) begin
        if (expected_kinds.size() == 0) begin
          report_mismatch($sformatf("reply kind %0d with no line pending", reply_kind));
        end else begin
          if (reply_kind !== expected_kinds[0])
            report_mismatch($sformatf("reply kind %0d, predicted %0d",
                                      reply_kind, expected_kinds[0]));
          void'(expected_kinds.pop_front());
        end
      end
      if (line_valid && !line_stall) take_char(line_byte, final_byte);
    end
    kinds_waiting <= expected_kinds.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the reply line classifier: line stimulus, reply stalls and verdict.
module tb_top;
  import cnc_rlc_pkg::*;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       line_valid  = 1'b0;
  logic [7:0] line_byte   = '0;
  logic       final_byte  = 1'b0;
  logic       reply_stall = 1'b0;
  logic       line_stall;
  logic       reply_valid;
  logic [3:0] reply_kind;
  int         fail_count;
  int         kinds_waiting;

  char_t line_q [$];
  int    chars_sent = 0;
  bit    quiet      = 1'b0;  // no idling on either side while set

  cnc_response_line_classifier DUT (
    .clk         (clk),
    .rst         (rst),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line_byte   (line_byte),
    .final_byte  (final_byte),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_kind  (reply_kind)
  );

  reply_kind_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .line_valid    (line_valid),
    .line_stall    (line_stall),
    .line_byte     (line_byte),
    .final_byte    (final_byte),
    .reply_valid   (reply_valid),
    .reply_stall   (reply_stall),
    .reply_kind    (reply_kind),
    .fail_count    (fail_count),
    .kinds_waiting (kinds_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Stall the reply channel for a random number of cycles per reply
  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        reply_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        reply_stall <= 1'b0;
      end
      do @(posedge clk); while (!reply_valid);
    end
  end

  // Send one character request, after a random gap, and hold it until taken
  task automatic send_char(input char_t b, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_valid <= 1'b1;
    line_byte  <= b;
    final_byte <= last;
    do @(posedge clk); while (line_stall);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(char_t'(s[i]));
  endtask

  task automatic add_filler(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(char_t'($urandom_range(32, 126)));
  endtask

  task automatic add_banner(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(START_TEXT[i]);
  endtask

  function automatic string keyword_text(input int k);
    case (k)
      0: return "ok";
      1: return "error";
      2: return "ALARM";
      3: return "to unlock";
      4: return "HLP";
      5: return "Unlocked";
      6: return "[Enabled]";
      7: return "[Disabled]";
      default: return "PRB";
    endcase
  endfunction

  // Keyword, now and then cut short by its last character
  task automatic add_keyword();
    string s;
    s = keyword_text($urandom_range(0, KwCount - 1));
    if ($urandom_range(0, 5) == 0) s = s.substr(0, s.len() - 2);
    add_text(s);
  endtask

  // Build one random line, mostly well formed with random content
  task automatic build_line();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) line_q.push_back(char_t'($urandom_range(0, 255)));
      end
      1: begin
        add_banner($urandom_range(1, 4));
        if ($urandom_range(0, 3) == 0) line_q[$urandom_range(0, line_q.size() - 1)] =
          char_t'($urandom_range(0, 255));
        add_filler($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) add_keyword();
      end
      2: begin
        add_text("<");
        add_filler($urandom_range(0, 10));
        if ($urandom_range(0, 2) == 0) add_keyword();
        if ($urandom_range(0, 4) != 0) add_text(">");
      end
      3, 4, 5: begin
        add_filler($urandom_range(0, 5));
        add_keyword();
        add_filler($urandom_range(0, 5));
        if ($urandom_range(0, 2) == 0) add_keyword();
      end
      6: begin
        if ($urandom_range(0, 4) != 0) add_text("$");
        add_filler($urandom_range(0, 4));
        if ($urandom_range(0, 4) != 0) add_text("=");
        add_filler($urandom_range(0, 4));
      end
      7: begin
        add_filler($urandom_range(12, 30));
        if ($urandom_range(0, 1) == 0) add_keyword();
        add_filler($urandom_range(0, 10));
      end
      8: begin
        add_text("$");
        add_filler($urandom_range(0, 3));
        add_keyword();
        add_text("=");
        add_filler($urandom_range(0, 3));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) add_banner(4); else add_text("<");
        add_keyword();
        if ($urandom_range(0, 1) == 0) add_text(">");
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed lines: banner edges, status edges, config edges, byte extremes
    add_banner(4);                              send_line();
    add_banner(3);                              send_line();
    add_banner(2); add_text("x"); add_banner(1); send_line();
    add_text("<>");                             send_line();
    add_text("<");                              send_line();
    add_text(">");                              send_line();
    add_text("<ok>");                           send_line();
    add_text("$=");                             send_line();
    add_text("=");                              send_line();
    add_text("$");                              send_line();
    line_q.push_back(8'h00);                    send_line();
    line_q.push_back(8'hFF);                    send_line();
    add_text("ok");                             send_line();

    // random lines until the item budget is used
    while (chars_sent < 1650) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      build_line();
      send_line();
    end
    line_valid <= 1'b0;

    // let the count of the last request settle, then drain outstanding replies
    @(posedge clk);
    drain = 0;
    while (kinds_waiting != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (12) @(posedge clk);

    if (fail_count == 0 && kinds_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cnc_rlc_pkg.sv
hdl/cnc_rlc_input_stage.sv
hdl/cnc_rlc_scan.sv
hdl/cnc_rlc_output_stage.sv
hdl/cnc_response_line_classifier.sv
hdl/cnc_rlc_checker.sv
bench/reply_kind_checker.sv
bench/tb_top.sv
